// ===== rtl/core/sfr_pkg.sv =====
// Shared constants and types for the serial frame receiver.
`default_nettype none

package sfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FCS_W       = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [BYTE_W-1:0] FLAG_BYTE   = 8'h7e;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h7d;
    localparam logic [BYTE_W-1:0] ESCAPE_XOR  = 8'h20;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_REVISION = 2'd2;

    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET        = 8'd68;
    localparam logic [BYTE_W-1:0] MIN_LENGTH_RESET        = 8'd4;
    localparam logic [BYTE_W-1:0] EXPECTED_REVISION_RESET = 8'd1;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] max_length;
        logic [BYTE_W-1:0] min_length;
        logic [BYTE_W-1:0] expected_revision;
    } sfr_cfg_t;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_good;
        logic [FCS_W-1:0]  received_fcs;
    } sfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfr_frame_fsm.sv =====
// Receive framing state machine: one byte per step, at most one result.
`default_nettype none

module sfr_frame_fsm (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [sfr_pkg::BYTE_W-1:0] rx_byte,
    input  wire sfr_pkg::sfr_cfg_t          cfg,
    output sfr_pkg::sfr_result_t            result
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_REV,
        PH_LEN,
        PH_DATA,
        PH_ESC,
        PH_FCS1,
        PH_FCS2,
        PH_END
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] expected_length_reg, expected_length_next;
    logic [BYTE_W-1:0] received_count_reg, received_count_next;
    logic [FCS_W-1:0]  fcs_value_reg, fcs_value_next;

    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] count_inc;
    logic              length_bad;

    assign count_inc  = received_count_reg + 8'd1;
    assign data_byte  = (phase_reg == PH_ESC) ? (rx_byte ^ ESCAPE_XOR) : rx_byte;
    assign length_bad = (rx_byte == '0) || (rx_byte > cfg.max_length)
                        || (rx_byte < cfg.min_length);

    always_comb
    begin
        phase_next           = phase_reg;
        expected_length_next = expected_length_reg;
        received_count_next  = received_count_reg;
        fcs_value_next       = fcs_value_reg;
        result               = '0;
        if (step)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (rx_byte == FLAG_BYTE)
                    begin
                        phase_next = PH_REV;
                    end
                end
                PH_REV:
                begin
                    phase_next = (rx_byte == cfg.expected_revision) ? PH_LEN : PH_START;
                end
                PH_LEN:
                begin
                    if (length_bad)
                    begin
                        phase_next = PH_START;
                    end
                    else
                    begin
                        expected_length_next = rx_byte;
                        received_count_next  = '0;
                        phase_next           = PH_DATA;
                    end
                end
                PH_DATA, PH_ESC:
                begin
                    if (phase_reg == PH_DATA && rx_byte == ESCAPE_BYTE)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        received_count_next = count_inc;
                        phase_next = (count_inc == expected_length_reg) ? PH_FCS1 : PH_DATA;
                        result.valid      = 1'b1;
                        result.kind       = KIND_DATA;
                        result.payload    = data_byte;
                        result.byte_index = received_count_reg;
                    end
                end
                PH_FCS1:
                begin
                    fcs_value_next = {rx_byte, 8'h00};
                    phase_next     = PH_FCS2;
                end
                PH_FCS2:
                begin
                    fcs_value_next = {fcs_value_reg[FCS_W-1:BYTE_W], rx_byte};
                    phase_next     = PH_END;
                end
                default:
                begin
                    // A missing end flag still closes the frame, as a drop.
                    phase_next          = PH_START;
                    result.valid        = 1'b1;
                    result.kind         = KIND_END;
                    result.frame_good   = (rx_byte == FLAG_BYTE);
                    result.received_fcs = fcs_value_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_START;
            expected_length_reg <= '0;
            received_count_reg  <= '0;
            fcs_value_reg       <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            expected_length_reg <= expected_length_next;
            received_count_reg  <= received_count_next;
            fcs_value_reg       <= fcs_value_next;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA || phase_reg == PH_ESC)
            |-> received_count_reg < expected_length_reg)
        else $error("payload count has reached the packet length inside the data");

    a_end_returns_to_start: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_END) |=> phase_reg == PH_START)
        else $error("framing machine did not return to start after the end byte");

    a_escape_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_ESC) |-> result.valid && result.kind == KIND_DATA)
        else $error("escaped byte produced no payload word");

    a_length_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> expected_length_reg != '0)
        else $error("data phase entered with a zero length");

endmodule

`default_nettype wire

// ===== rtl/core/serial_frame_receiver.sv =====
// Serial frame receiver top level: input register, framing machine, result register.
// A byte sits in the input register; a result word from it is loaded into the result register.
// Throughput: one byte per cycle; the input register drains whenever the result register is free.
// The framing machine itself is single-pass logic between the two registers.
// Reset clears the pipeline valids and the framing state and loads the register defaults.
`default_nettype none

module serial_frame_receiver (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [sfr_pkg::BYTE_W-1:0]      rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 kind,
    output logic [sfr_pkg::BYTE_W-1:0]           payload,
    output logic [sfr_pkg::BYTE_W-1:0]           byte_index,
    output logic                                 frame_good,
    output logic [sfr_pkg::FCS_W-1:0]            received_fcs,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::BYTE_W-1:0]      cfg_data
);
    import sfr_pkg::*;

    sfr_cfg_t          cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    sfr_result_t       out_reg;
    sfr_result_t       result;
    logic              out_free;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length        <= MAX_LENGTH_RESET;
            cfg_reg.min_length        <= MIN_LENGTH_RESET;
            cfg_reg.expected_revision <= EXPECTED_REVISION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_LENGTH:        cfg_reg.max_length        <= cfg_data;
                CFG_MIN_LENGTH:        cfg_reg.min_length        <= cfg_data;
                CFG_EXPECTED_REVISION: cfg_reg.expected_revision <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && result.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    sfr_frame_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign payload      = out_reg.payload;
    assign byte_index   = out_reg.byte_index;
    assign frame_good   = out_reg.frame_good;
    assign received_fcs = out_reg.received_fcs;

    a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_stall) |-> !in_stall)
        else $error("input word held although the result register could take it");

    a_data_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_DATA)
            |-> !out_reg.frame_good && out_reg.received_fcs == '0)
        else $error("payload word carries end status fields");

    a_end_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == KIND_END)
            |-> out_reg.payload == '0 && out_reg.byte_index == '0)
        else $error("end word carries payload fields");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
